// ----- rtl/servo_angle_to_drive_unit_defines.svh -----
// assertion macros used by the file that checks this block
`ifndef SERVO_ANGLE_TO_DRIVE_UNIT_DEFINES_SVH
`define SERVO_ANGLE_TO_DRIVE_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define SATD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define SATD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/satd_pkg.sv -----
`default_nettype none

package satd_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIRECTION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_RANGE        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SERVO_ID          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_OFFSET   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN          = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX          = 3'd7;

	// register reset values
	localparam logic        RST_OUTPUT_MODE       = 1'b0;
	localparam logic        RST_REVERSE_DIRECTION = 1'b0;
	localparam logic [14:0] RST_HALF_RANGE        = 15'd1440;
	localparam logic [7:0]  RST_SERVO_ID          = 8'd1;
	localparam logic [15:0] RST_POSITION_GAIN     = 16'd256;
	localparam logic [15:0] RST_POSITION_OFFSET   = 16'd0;
	localparam logic [15:0] RST_DUTY_MIN          = 16'd3277;
	localparam logic [15:0] RST_DUTY_MAX          = 16'd6554;

	// output modes and result kinds
	localparam logic MODE_PWM    = 1'b0;
	localparam logic MODE_BUS    = 1'b1;
	localparam logic KIND_DUTY   = 1'b0;
	localparam logic KIND_PACKET = 1'b1;

	// bus packet contents
	localparam logic [7:0]  SYNC_BYTE         = 8'hFF;
	localparam logic [7:0]  PKT_LEN_FIELD     = 8'h09;
	localparam logic [7:0]  WRITE_INSTRUCTION = 8'd3;
	localparam logic [7:0]  TARGET_REGISTER   = 8'd42;
	localparam logic [15:0] MOVE_TIME         = 16'd0;
	localparam logic [15:0] MOVE_SPEED        = 16'd0;

	// byte positions within the packet
	localparam int BYTE_IDX_W = 4;
	localparam logic [BYTE_IDX_W-1:0] PB_SYNC0    = 4'd0;
	localparam logic [BYTE_IDX_W-1:0] PB_SYNC1    = 4'd1;
	localparam logic [BYTE_IDX_W-1:0] PB_ID       = 4'd2;
	localparam logic [BYTE_IDX_W-1:0] PB_LEN      = 4'd3;
	localparam logic [BYTE_IDX_W-1:0] PB_INSTR    = 4'd4;
	localparam logic [BYTE_IDX_W-1:0] PB_REG      = 4'd5;
	localparam logic [BYTE_IDX_W-1:0] PB_POS_LO   = 4'd6;
	localparam logic [BYTE_IDX_W-1:0] PB_POS_HI   = 4'd7;
	localparam logic [BYTE_IDX_W-1:0] PB_TIME_LO  = 4'd8;
	localparam logic [BYTE_IDX_W-1:0] PB_TIME_HI  = 4'd9;
	localparam logic [BYTE_IDX_W-1:0] PB_SPEED_LO = 4'd10;
	localparam logic [BYTE_IDX_W-1:0] PB_SPEED_HI = 4'd11;
	localparam logic [BYTE_IDX_W-1:0] PB_CHECKSUM = 4'd12;

	// duty divider: quotient bits, bits per stage, stage count
	localparam int DIV_BITS   = 16;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

	typedef struct packed {
		logic        output_mode;
		logic        reverse_direction;
		logic [14:0] half_range;
		logic [7:0]  servo_id;
		logic [15:0] position_gain;
		logic [15:0] position_offset;
		logic [15:0] duty_min;
		logic [15:0] duty_max;
	} cfg_t;

	// word carried down the pipeline
	typedef struct packed {
		logic        bus;
		logic [15:0] angle;
		logic [15:0] pos;
		logic [15:0] rem;
		logic [15:0] quo;
	} work_t;

endpackage

`default_nettype wire

// ----- rtl/satd_if.sv -----
`default_nettype none

// command channel: one target angle per word
interface satd_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] target_angle;

	modport source(output valid, output target_angle, input ready);
	modport sink(input valid, input target_angle, output ready);
endinterface

// drive channel: duty result or one packet byte per word
interface satd_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [15:0] duty_value;
	logic [15:0] clamped_angle;
	logic [7:0]  packet_byte;
	logic        last_byte;

	modport source(output valid, output result_kind, output duty_value,
		output clamped_angle, output packet_byte, output last_byte, input ready);
	modport sink(input valid, input result_kind, input duty_value,
		input clamped_angle, input packet_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/satd_cfg.sv -----
`default_nettype none

module satd_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [satd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [satd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output satd_pkg::cfg_t                        cfg
);

	satd_pkg::cfg_t cfg_q;

	// register file, written by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_mode       <= satd_pkg::RST_OUTPUT_MODE;
			cfg_q.reverse_direction <= satd_pkg::RST_REVERSE_DIRECTION;
			cfg_q.half_range        <= satd_pkg::RST_HALF_RANGE;
			cfg_q.servo_id          <= satd_pkg::RST_SERVO_ID;
			cfg_q.position_gain     <= satd_pkg::RST_POSITION_GAIN;
			cfg_q.position_offset   <= satd_pkg::RST_POSITION_OFFSET;
			cfg_q.duty_min          <= satd_pkg::RST_DUTY_MIN;
			cfg_q.duty_max          <= satd_pkg::RST_DUTY_MAX;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				satd_pkg::REG_OUTPUT_MODE:       cfg_q.output_mode <= cfg_wdata[0];
				satd_pkg::REG_REVERSE_DIRECTION: cfg_q.reverse_direction <= cfg_wdata[0];
				satd_pkg::REG_HALF_RANGE:        cfg_q.half_range <= cfg_wdata[14:0];
				satd_pkg::REG_SERVO_ID:          cfg_q.servo_id <= cfg_wdata[7:0];
				satd_pkg::REG_POSITION_GAIN:     cfg_q.position_gain <= cfg_wdata;
				satd_pkg::REG_POSITION_OFFSET:   cfg_q.position_offset <= cfg_wdata;
				satd_pkg::REG_DUTY_MIN:          cfg_q.duty_min <= cfg_wdata;
				satd_pkg::REG_DUTY_MAX:          cfg_q.duty_max <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/satd_front.sv -----
`default_nettype none

module satd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	satd_in_if.sink            cmd,
	input  wire satd_pkg::cfg_t cfg,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output satd_pkg::work_t    dn_work
);

	// stage 1: direction, clamp, multiplier operand select
	logic signed [16:0] a_in, a_dir, h_pos, h_neg, a_clamp;
	logic signed [17:0] x_pwm, y_bus;
	logic signed [16:0] d_span, d_neg;
	logic [15:0]        d_mag;

	logic               valid_s1, ready_s1, bus_s1;
	logic signed [17:0] mul_a_s1;
	logic [15:0]        mul_b_s1;
	logic [15:0]        angle_s1;

	logic               valid_s2, ready_s2, bus_s2;
	logic signed [34:0] prod_c, prod_s2;
	logic [15:0]        angle_s2;

	logic               valid_s3, ready_s3;
	logic signed [35:0] off_sh, t_c;
	logic [15:0]        pos_c;
	satd_pkg::work_t    work_s3;

	assign a_in    = {cmd.target_angle[15], cmd.target_angle};
	assign a_dir   = cfg.reverse_direction ? -a_in : a_in;
	assign h_pos   = {2'b00, cfg.half_range};
	assign h_neg   = -h_pos;
	assign a_clamp = (a_dir > h_pos) ? h_pos : ((a_dir < h_neg) ? h_neg : a_dir);
	assign x_pwm   = {a_clamp[16], a_clamp} + {1'b0, h_pos};
	assign y_bus   = {a_dir[16], a_dir} + {1'b0, h_pos};

	// magnitude of the duty span, sign handled at the end
	assign d_span = {1'b0, cfg.duty_max} - {1'b0, cfg.duty_min};
	assign d_neg  = -d_span;
	assign d_mag  = d_span[16] ? d_neg[15:0] : d_span[15:0];

	assign ready_s1  = !valid_s1 || ready_s2;
	assign cmd.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && ready_s1) begin
			bus_s1   <= (cfg.output_mode == satd_pkg::MODE_BUS);
			mul_a_s1 <= (cfg.output_mode == satd_pkg::MODE_BUS) ? y_bus : x_pwm;
			mul_b_s1 <= (cfg.output_mode == satd_pkg::MODE_BUS) ? cfg.position_gain : d_mag;
			angle_s1 <= a_clamp[15:0];
		end
	end

	// stage 2: shared multiplier
	assign prod_c   = 35'(mul_a_s1) * 35'($signed({1'b0, mul_b_s1}));
	assign ready_s2 = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			bus_s2   <= bus_s1;
			prod_s2  <= prod_c;
			angle_s2 <= angle_s1;
		end
	end

	// stage 3: bus position offset and saturation, divider set-up
	assign off_sh = {{12{cfg.position_offset[15]}}, cfg.position_offset, 8'h00};
	assign t_c    = {prod_s2[34], prod_s2} + off_sh;
	assign pos_c  = t_c[35] ? 16'h0000 : ((|t_c[34:24]) ? 16'hFFFF : t_c[23:8]);

	assign ready_s3 = !valid_s3 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			work_s3.bus   <= bus_s2;
			work_s3.angle <= angle_s2;
			work_s3.pos   <= pos_c;
			work_s3.rem   <= prod_s2[31:16];
			work_s3.quo   <= prod_s2[15:0];
		end
	end

	assign dn_valid = valid_s3;
	assign dn_work  = work_s3;

endmodule

`default_nettype wire

// ----- rtl/satd_div_stage.sv -----
`default_nettype none

module satd_div_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire satd_pkg::cfg_t  cfg,
	input  wire logic            up_valid,
	output logic                 up_ready,
	input  wire satd_pkg::work_t up_work,
	output logic                 dn_valid,
	input  wire logic            dn_ready,
	output satd_pkg::work_t      dn_work
);

	logic [15:0]     divisor;
	logic [16:0]     trial;
	logic [15:0]     rem_c, quo_c;
	logic            qbit;
	satd_pkg::work_t next_c;

	logic            valid_s1;
	satd_pkg::work_t work_s1;

	// divisor is twice the half range
	assign divisor = {cfg.half_range, 1'b0};

	// restoring division, two quotient bits per stage
	always_comb begin
		rem_c = up_work.rem;
		quo_c = up_work.quo;
		trial = 17'd0;
		qbit  = 1'b0;
		for (int i = 0; i < satd_pkg::DIV_STEPS; i++) begin
			trial = {rem_c, quo_c[15]};
			qbit  = (trial >= {1'b0, divisor});
			rem_c = qbit ? 16'(trial - {1'b0, divisor}) : trial[15:0];
			quo_c = {quo_c[14:0], qbit};
		end
		next_c     = up_work;
		next_c.rem = rem_c;
		next_c.quo = quo_c;
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			work_s1 <= next_c;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_work  = work_s1;

endmodule

`default_nettype wire

// ----- rtl/satd_tx.sv -----
`default_nettype none

module satd_tx (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire satd_pkg::cfg_t  cfg,
	input  wire logic            up_valid,
	output logic                 up_ready,
	input  wire satd_pkg::work_t up_work,
	satd_out_if.source           drv
);

	logic        span_neg, rem_nz, load;
	logic [15:0] duty_c;
	logic [7:0]  sum_c;

	logic                              busy_q, kind_q;
	logic [satd_pkg::BYTE_IDX_W-1:0]   byte_q;
	logic [15:0]                       duty_q, angle_q, pos_q;
	logic [7:0]                        chk_q;
	logic [7:0]                        byte_mux;
	logic                              last_c;

	// duty from quotient: round toward minus infinity for a falling span
	assign span_neg = (cfg.duty_max < cfg.duty_min);
	assign rem_nz   = |up_work.rem;
	assign duty_c   = (cfg.half_range == 15'd0) ? cfg.duty_min :
		(span_neg ? (cfg.duty_min - up_work.quo - {15'd0, rem_nz})
			: (cfg.duty_min + up_work.quo));

	// checksum over id through speed
	assign sum_c = cfg.servo_id + satd_pkg::PKT_LEN_FIELD + satd_pkg::WRITE_INSTRUCTION
		+ satd_pkg::TARGET_REGISTER + up_work.pos[7:0] + up_work.pos[15:8]
		+ satd_pkg::MOVE_TIME[7:0] + satd_pkg::MOVE_TIME[15:8]
		+ satd_pkg::MOVE_SPEED[7:0] + satd_pkg::MOVE_SPEED[15:8];

	assign last_c   = (kind_q == satd_pkg::KIND_DUTY) || (byte_q == satd_pkg::PB_CHECKSUM);
	assign up_ready = !busy_q || (drv.ready && last_c);
	assign load     = up_valid && up_ready;

	// word sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= satd_pkg::KIND_DUTY;
			byte_q <= satd_pkg::PB_SYNC0;
		end else begin
			if (busy_q && drv.ready) begin
				if (last_c) begin
					busy_q <= 1'b0;
				end else begin
					byte_q <= byte_q + 1'b1;
				end
			end
			if (load) begin
				busy_q <= 1'b1;
				kind_q <= up_work.bus ? satd_pkg::KIND_PACKET : satd_pkg::KIND_DUTY;
				byte_q <= satd_pkg::PB_SYNC0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			duty_q  <= duty_c;
			angle_q <= up_work.angle;
			pos_q   <= up_work.pos;
			chk_q   <= ~sum_c;
		end
	end

	// packet byte select
	always_comb begin
		unique case (byte_q)
			satd_pkg::PB_SYNC0:    byte_mux = satd_pkg::SYNC_BYTE;
			satd_pkg::PB_SYNC1:    byte_mux = satd_pkg::SYNC_BYTE;
			satd_pkg::PB_ID:       byte_mux = cfg.servo_id;
			satd_pkg::PB_LEN:      byte_mux = satd_pkg::PKT_LEN_FIELD;
			satd_pkg::PB_INSTR:    byte_mux = satd_pkg::WRITE_INSTRUCTION;
			satd_pkg::PB_REG:      byte_mux = satd_pkg::TARGET_REGISTER;
			satd_pkg::PB_POS_LO:   byte_mux = pos_q[7:0];
			satd_pkg::PB_POS_HI:   byte_mux = pos_q[15:8];
			satd_pkg::PB_TIME_LO:  byte_mux = satd_pkg::MOVE_TIME[7:0];
			satd_pkg::PB_TIME_HI:  byte_mux = satd_pkg::MOVE_TIME[15:8];
			satd_pkg::PB_SPEED_LO: byte_mux = satd_pkg::MOVE_SPEED[7:0];
			satd_pkg::PB_SPEED_HI: byte_mux = satd_pkg::MOVE_SPEED[15:8];
			satd_pkg::PB_CHECKSUM: byte_mux = chk_q;
			default:               byte_mux = 8'h00;
		endcase
	end

	assign drv.valid         = busy_q;
	assign drv.result_kind   = kind_q;
	assign drv.duty_value    = (kind_q == satd_pkg::KIND_DUTY) ? duty_q : 16'h0000;
	assign drv.clamped_angle = (kind_q == satd_pkg::KIND_DUTY) ? angle_q : 16'h0000;
	assign drv.packet_byte   = (kind_q == satd_pkg::KIND_PACKET) ? byte_mux : 8'h00;
	assign drv.last_byte     = last_c;

endmodule

`default_nettype wire

// ----- rtl/servo_angle_to_drive_unit.sv -----
`default_nettype none
`include "servo_angle_to_drive_unit_defines.svh"

// Servo drive unit: takes a signed target angle (1/16 degree) on cmd and returns on drv
// either one PWM duty word with the clamped angle (output_mode 0) or a 13-word bus write
// packet, one byte per word (output_mode 1). An angle passes three front stages (direction
// and clamp, a shared 18x17 multiplier, offset and saturation), eight divider stages of two
// quotient bits each, and the output register. In PWM mode a new angle is taken every cycle
// while drv is ready; in bus mode the output register sends one packet byte per cycle while drv
// is ready and takes the next angle as the checksum byte is taken. The user must write registers
// through cfg_we, cfg_idx and cfg_wdata only while no angle is in flight; the block does not enforce it.
module servo_angle_to_drive_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	satd_in_if.sink                               cmd,
	satd_out_if.source                            drv,
	input  wire logic                             cfg_we,
	input  wire logic [satd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [satd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	satd_pkg::cfg_t  cfg;
	logic            stage_v   [0:satd_pkg::DIV_STAGES];
	logic            stage_rdy [0:satd_pkg::DIV_STAGES];
	satd_pkg::work_t stage_work[0:satd_pkg::DIV_STAGES];

	// register file
	satd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// front stages
	satd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.dn_valid (stage_v[0]),
		.dn_ready (stage_rdy[0]),
		.dn_work  (stage_work[0])
	);

	// divider pipeline
	for (genvar g = 0; g < satd_pkg::DIV_STAGES; g++) begin : g_div
		satd_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg),
			.up_valid (stage_v[g]),
			.up_ready (stage_rdy[g]),
			.up_work  (stage_work[g]),
			.dn_valid (stage_v[g+1]),
			.dn_ready (stage_rdy[g+1]),
			.dn_work  (stage_work[g+1])
		);
	end

	// output register and packet sequencer
	satd_tx u_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (stage_v[satd_pkg::DIV_STAGES]),
		.up_ready (stage_rdy[satd_pkg::DIV_STAGES]),
		.up_work  (stage_work[satd_pkg::DIV_STAGES]),
		.drv      (drv)
	);

	// checks
	`SATD_ASSERT_SAME(a_duty_single, drv.valid && (drv.result_kind == satd_pkg::KIND_DUTY), drv.last_byte, "duty word not marked last")
	`SATD_ASSERT_NEXT(a_packet_runs, drv.valid && drv.ready && !drv.last_byte, drv.valid && (drv.result_kind == satd_pkg::KIND_PACKET), "packet broken off")
	`SATD_ASSERT_SAME(a_packet_clean, drv.valid && (drv.result_kind == satd_pkg::KIND_PACKET), (drv.duty_value == 16'h0000) && (drv.clamped_angle == 16'h0000), "duty fields set in packet word")

endmodule

`default_nettype wire
